// ===== src/rci_pkg.sv =====
`timescale 1ns / 1ps

package rci_pkg;

  // Field widths of the exact fixed-point datapath
  localparam int unsigned W_X   = 33;   // origin - apex
  localparam int unsigned W_BB  = 66;   // D.D
  localparam int unsigned W_DV  = 53;   // D.V and x.V
  localparam int unsigned W_BX  = 67;   // D.x
  localparam int unsigned W_XX  = 68;   // x.x
  localparam int unsigned W_M   = 64;   // 2^32 + k^2
  localparam int unsigned W_K   = 166;  // K1, H, K3
  localparam int unsigned W_Q   = 332;  // H^2 - K1 K3
  localparam int unsigned W_R   = W_Q / 2;
  localparam int unsigned W_N   = 184;  // (-H +- r) * 2^16
  localparam int unsigned QW    = 32;   // quotient bits
  localparam int unsigned MUL_DIG = 16;

  typedef enum logic [2:0] {
    CFG_APEX_X = 3'd0,
    CFG_APEX_Y = 3'd1,
    CFG_APEX_Z = 3'd2,
    CFG_AXIS_X = 3'd3,
    CFG_AXIS_Y = 3'd4,
    CFG_AXIS_Z = 3'd5,
    CFG_SLOPE  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] root_plus;
    logic signed [31:0] root_minus;
    logic               hit;
  } out_t;

  typedef struct packed {
    logic signed [W_BB-1:0] bb;
    logic signed [W_BX-1:0] bx;
    logic signed [W_XX-1:0] xx;
  } dot_t;

  typedef struct packed {
    logic signed [W_K-1:0] k1;
    logic signed [W_K-1:0] h;
  } kh_t;

  typedef struct packed {
    logic signed [W_K-1:0] k1;
    logic signed [W_K-1:0] h;
    logic                  hit;
  } sq_t;

  typedef struct packed {
    logic neg_p;
    logic neg_m;
    logic hit;
  } dsd_t;

  // Clamp a truncated quotient magnitude to the signed 32-bit range
  function automatic logic [31:0] sat_root(logic [QW-1:0] q, logic big, logic neg);
    logic [31:0] mag;
    if (neg) begin
      mag = (big || q > 32'h8000_0000) ? 32'h8000_0000 : q;
      return 32'd0 - mag;
    end else begin
      return (big || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
    end
  endfunction

endpackage

// ===== src/rci_mul.sv =====
`timescale 1ns / 1ps

module rci_mul #(
  parameter int unsigned LANES = 1,
  parameter int unsigned WA    = 16,
  parameter int unsigned WB    = 16,
  parameter int unsigned DIG   = 16,
  parameter int unsigned SW    = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [LANES-1:0][WA-1:0]         a_i,
  input  logic [LANES-1:0][WB-1:0]         b_i,
  input  logic [SW-1:0]                    side_i,
  output logic                             valid_o,
  output logic [LANES-1:0][WA+WB-1:0]      p_o,
  output logic [SW-1:0]                    side_o
);

  localparam int unsigned NS  = (WB + DIG - 1) / DIG;
  localparam int unsigned WBX = NS * DIG;
  localparam int unsigned WP  = WA + WB;
  localparam int unsigned PW  = WA + DIG + 1;

  logic [NS:0]                        vld_q;
  logic [NS-1:0][LANES-1:0][WA-1:0]   a_q;
  logic [NS-1:0][LANES-1:0][WBX-1:0]  b_q;
  logic [NS:0][LANES-1:0][WP-1:0]     acc_q;
  logic [NS:0][SW-1:0]                sd_q;

  assign vld_q[0] = valid_i;
  assign sd_q[0]  = side_i;
  assign acc_q[0] = '0;

  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign a_q[0][l] = a_i[l];
    assign b_q[0][l] = WBX'($signed(b_i[l]));
  end

  // One digit of B per stage; the top digit carries the sign
  for (genvar j = 0; j < NS; j++) begin : g_st
    logic [LANES-1:0][WP-1:0] acc_d;

    for (genvar l = 0; l < LANES; l++) begin : g_ln
      logic signed [PW-1:0] pp;
      if (j == NS - 1) begin : g_top
        assign pp = PW'($signed(a_q[j][l]) * $signed(b_q[j][l][j*DIG +: DIG]));
      end else begin : g_low
        assign pp = PW'($signed(a_q[j][l]) * $signed({1'b0, b_q[j][l][j*DIG +: DIG]}));
      end
      assign acc_d[l] = acc_q[j][l] + (WP'(pp) << (j * DIG));
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[j+1] <= acc_d;
        sd_q[j+1]  <= sd_q[j];
      end
    end

    if (j < NS - 1) begin : g_fw
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          a_q[j+1] <= a_q[j];
          b_q[j+1] <= b_q[j];
        end
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign p_o     = acc_q[NS];
  assign side_o  = sd_q[NS];

endmodule

// ===== src/rci_sqrt.sv =====
`timescale 1ns / 1ps

module rci_sqrt #(
  parameter int unsigned WQ = 16,
  parameter int unsigned SW = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [WQ-1:0]      q_i,
  input  logic [SW-1:0]      side_i,
  output logic               valid_o,
  output logic [WQ/2-1:0]    root_o,
  output logic [SW-1:0]      side_o
);

  localparam int unsigned NR = WQ / 2;
  localparam int unsigned WR = NR + 2;

  logic [NR:0]               vld_q;
  logic [NR-1:0][WQ-1:0]     q_q;
  logic [NR-1:0][WR-1:0]     rem_q;
  logic [NR:0][NR-1:0]       root_q;
  logic [NR:0][SW-1:0]       sd_q;

  assign vld_q[0]  = valid_i;
  assign q_q[0]    = q_i;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign sd_q[0]   = side_i;

  // One root bit per stage, two radicand bits from the top down
  for (genvar j = 0; j < NR; j++) begin : g_st
    logic [WR-1:0] cur;
    logic [WR-1:0] trial;
    logic          ge;

    assign cur   = {rem_q[j][NR-1:0], q_q[j][WQ-1-2*j -: 2]};
    assign trial = {root_q[j], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[j+1] <= vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[j+1] <= {root_q[j][NR-2:0], ge};
        sd_q[j+1]   <= sd_q[j];
      end
    end

    if (j < NR - 1) begin : g_fw
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= ge ? (cur - trial) : cur;
          q_q[j+1]   <= q_q[j];
        end
      end
    end
  end

  assign valid_o = vld_q[NR];
  assign root_o  = root_q[NR];
  assign side_o  = sd_q[NR];

endmodule

// ===== src/ray_cone_intersection.sv =====
`timescale 1ns / 1ps
// Ray against double cone.
// Throughput one ray per cycle; every stage is registered and the whole pipe
// advances together unless the two-beat output buffer is full.
// Depth is set by the 166-stage square root and the 33-stage divider.
// Reset clears all valid bits and loads the cone registers with their defaults.
module ray_cone_intersection #(
  parameter logic [31:0] MAX_DISTANCE = 32'h7FFF_FFFF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rci_pkg::in_t        in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rci_pkg::out_t       out_data_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);

  localparam int unsigned W_X  = rci_pkg::W_X;
  localparam int unsigned W_DV = rci_pkg::W_DV;
  localparam int unsigned W_K  = rci_pkg::W_K;
  localparam int unsigned W_Q  = rci_pkg::W_Q;
  localparam int unsigned W_R  = rci_pkg::W_R;
  localparam int unsigned W_N  = rci_pkg::W_N;
  localparam int unsigned QW   = rci_pkg::QW;
  localparam int unsigned CW   = W_K + QW;
  localparam int unsigned W_M  = rci_pkg::W_M;
  localparam int unsigned DIG  = rci_pkg::MUL_DIG;

  // ---------------------------------------------------------------------------
  // Cone registers. m_q = 2^32 + slope^2 is registered from slope and follows it in the
  // next cycle; the first ray after a write reaches the stage that reads it much later.
  // ---------------------------------------------------------------------------
  logic signed [31:0] apex_q [3];
  logic signed [17:0] axis_q [3];
  logic [30:0]        slope_q;
  logic [W_M-1:0]     m_q;
  logic [61:0]        slope_sq;

  assign slope_sq = slope_q * slope_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apex_q[0] <= '0;
      apex_q[1] <= '0;
      apex_q[2] <= '0;
      axis_q[0] <= '0;
      axis_q[1] <= 18'sh10000;
      axis_q[2] <= '0;
      slope_q   <= 31'h10000;
      m_q       <= 64'h2_0000_0000;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rci_pkg::CFG_APEX_X: apex_q[0] <= cfg_data_i;
          rci_pkg::CFG_APEX_Y: apex_q[1] <= cfg_data_i;
          rci_pkg::CFG_APEX_Z: apex_q[2] <= cfg_data_i;
          rci_pkg::CFG_AXIS_X: axis_q[0] <= cfg_data_i[17:0];
          rci_pkg::CFG_AXIS_Y: axis_q[1] <= cfg_data_i[17:0];
          rci_pkg::CFG_AXIS_Z: axis_q[2] <= cfg_data_i[17:0];
          rci_pkg::CFG_SLOPE:  slope_q   <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      m_q <= {2'b00, slope_sq} + 64'h1_0000_0000;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipe advance. The output buffer holds two beats; stall only when both are
  // occupied, so a new ray is still taken while one result waits.
  // ---------------------------------------------------------------------------
  logic [1:0] cnt_q, cnt_d;
  logic       en;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  // Stage 1: x = origin - apex
  logic                  v1_q;
  logic signed [W_X-1:0] x1_q [3];
  logic signed [31:0]    d1_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_q[0] <= W_X'(in_data_i.origin_x) - W_X'(apex_q[0]);
      x1_q[1] <= W_X'(in_data_i.origin_y) - W_X'(apex_q[1]);
      x1_q[2] <= W_X'(in_data_i.origin_z) - W_X'(apex_q[2]);
      d1_q[0] <= in_data_i.dir_x;
      d1_q[1] <= in_data_i.dir_y;
      d1_q[2] <= in_data_i.dir_z;
    end
  end

  // Stage 2: fifteen component products
  logic               v2_q;
  logic signed [63:0] p_dd_q [3];
  logic signed [49:0] p_dv_q [3];
  logic signed [64:0] p_dx_q [3];
  logic signed [50:0] p_xv_q [3];
  logic signed [65:0] p_xx_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_dd_q[i] <= d1_q[i] * d1_q[i];
        p_dv_q[i] <= d1_q[i] * axis_q[i];
        p_dx_q[i] <= d1_q[i] * x1_q[i];
        p_xv_q[i] <= x1_q[i] * axis_q[i];
        p_xx_q[i] <= x1_q[i] * x1_q[i];
      end
    end
  end

  // Stage 3: dot products
  logic                   v3_q;
  rci_pkg::dot_t          dot_q;
  logic signed [W_DV-1:0] bv_q, xv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      dot_q.bb <= rci_pkg::W_BB'(p_dd_q[0]) + rci_pkg::W_BB'(p_dd_q[1])
                + rci_pkg::W_BB'(p_dd_q[2]);
      dot_q.bx <= rci_pkg::W_BX'(p_dx_q[0]) + rci_pkg::W_BX'(p_dx_q[1])
                + rci_pkg::W_BX'(p_dx_q[2]);
      dot_q.xx <= rci_pkg::W_XX'(p_xx_q[0]) + rci_pkg::W_XX'(p_xx_q[1])
                + rci_pkg::W_XX'(p_xx_q[2]);
      bv_q     <= W_DV'(p_dv_q[0]) + W_DV'(p_dv_q[1]) + W_DV'(p_dv_q[2]);
      xv_q     <= W_DV'(p_xv_q[0]) + W_DV'(p_xv_q[1]) + W_DV'(p_xv_q[2]);
    end
  end

  // Multiply 1: (D.V)^2, (D.V)(x.V), (x.V)^2
  logic [2:0][W_DV-1:0]   m1_a, m1_b;
  logic [2:0][2*W_DV-1:0] m1_p;
  logic                   m1_v;
  rci_pkg::dot_t          m1_sd;

  assign m1_a[0] = bv_q;
  assign m1_a[1] = bv_q;
  assign m1_a[2] = xv_q;
  assign m1_b[0] = bv_q;
  assign m1_b[1] = xv_q;
  assign m1_b[2] = xv_q;

  rci_mul #(
    .LANES(3), .WA(W_DV), .WB(W_DV), .DIG(DIG), .SW($bits(rci_pkg::dot_t))
  ) u_mul_v (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q),
    .a_i(m1_a), .b_i(m1_b), .side_i(dot_q),
    .valid_o(m1_v), .p_o(m1_p), .side_o(m1_sd)
  );

  // Multiply 2: scale by M
  logic [2:0][W_M-1:0]          m2_b;
  logic [2:0][2*W_DV+W_M-1:0]   m2_p;
  logic                         m2_v;
  rci_pkg::dot_t                m2_sd;

  assign m2_b[0] = m_q;
  assign m2_b[1] = m_q;
  assign m2_b[2] = m_q;

  rci_mul #(
    .LANES(3), .WA(2*W_DV), .WB(W_M), .DIG(DIG), .SW($bits(rci_pkg::dot_t))
  ) u_mul_m (
    .clk_i, .rst_ni, .en_i(en), .valid_i(m1_v),
    .a_i(m1_p), .b_i(m2_b), .side_i(m1_sd),
    .valid_o(m2_v), .p_o(m2_p), .side_o(m2_sd)
  );

  // Stage K: K1, H, K3 with the dot terms lifted by 2^64
  logic                  vk_q;
  logic signed [W_K-1:0] k1_q, h_q, k3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      k1_q <= (W_K'(m2_sd.bb) << 64) - W_K'(m2_p[0]);
      h_q  <= (W_K'(m2_sd.bx) << 64) - W_K'(m2_p[1]);
      k3_q <= (W_K'(m2_sd.xx) << 64) - W_K'(m2_p[2]);
    end
  end

  // Multiply 3: H^2 and K1 K3
  logic [1:0][W_K-1:0]   m3_a, m3_b;
  logic [1:0][2*W_K-1:0] m3_p;
  logic                  m3_v;
  rci_pkg::kh_t          m3_si, m3_sd;

  assign m3_a[0]  = h_q;
  assign m3_b[0]  = h_q;
  assign m3_a[1]  = k1_q;
  assign m3_b[1]  = k3_q;
  assign m3_si.k1 = k1_q;
  assign m3_si.h  = h_q;

  rci_mul #(
    .LANES(2), .WA(W_K), .WB(W_K), .DIG(DIG), .SW($bits(rci_pkg::kh_t))
  ) u_mul_q (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vk_q),
    .a_i(m3_a), .b_i(m3_b), .side_i(m3_si),
    .valid_o(m3_v), .p_o(m3_p), .side_o(m3_sd)
  );

  // Stage Q: discriminant over four; zero it when negative so the root is benign
  logic            vq_q;
  logic [W_Q-1:0]  qr_q;
  rci_pkg::sq_t    sq_q;
  logic [W_Q-1:0]  q_diff;

  assign q_diff = m3_p[0] - m3_p[1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      qr_q      <= q_diff[W_Q-1] ? '0 : q_diff;
      sq_q.k1   <= m3_sd.k1;
      sq_q.h    <= m3_sd.h;
      sq_q.hit  <= !q_diff[W_Q-1] && (m3_sd.k1 != '0);
    end
  end

  // Square root
  logic            sr_v;
  logic [W_R-1:0]  sr_root;
  rci_pkg::sq_t    sr_sd;

  rci_sqrt #(
    .WQ(W_Q), .SW($bits(rci_pkg::sq_t))
  ) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vq_q),
    .q_i(qr_q), .side_i(sq_q),
    .valid_o(sr_v), .root_o(sr_root), .side_o(sr_sd)
  );

  // Stage R: numerators (-H +- r) * 2^16
  logic                  vr_q;
  logic [W_N-1:0]        np_q, nm_q;
  logic signed [W_K-1:0] k1r_q;
  logic                  hitr_q;
  logic [W_N-1:0]        nh;

  assign nh = W_N'(0) - W_N'(sr_sd.h);

  always_ff @(posedge clk_i) begin
    if (en) begin
      np_q   <= (nh + W_N'(sr_root)) << 16;
      nm_q   <= (nh - W_N'(sr_root)) << 16;
      k1r_q  <= sr_sd.k1;
      hitr_q <= sr_sd.hit;
    end
  end

  // Stage A: magnitudes and quotient signs
  logic                  va_q;
  logic [1:0][W_N-1:0]   an_q;
  logic [W_K-1:0]        ad_q;
  rci_pkg::dsd_t         asd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      an_q[0]     <= np_q[W_N-1] ? (W_N'(0) - np_q) : np_q;
      an_q[1]     <= nm_q[W_N-1] ? (W_N'(0) - nm_q) : nm_q;
      ad_q        <= k1r_q[W_K-1] ? (W_K'(0) - k1r_q) : k1r_q;
      asd_q.neg_p <= np_q[W_N-1] ^ k1r_q[W_K-1];
      asd_q.neg_m <= nm_q[W_N-1] ^ k1r_q[W_K-1];
      asd_q.hit   <= hitr_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Divider: an overflow check against |K1| * 2^32, then one restoring step per
  // quotient bit. Both roots share the divisor.
  // ---------------------------------------------------------------------------
  logic [QW:0]          dv_q;
  logic [1:0][W_N-1:0]  drem_q [QW];
  logic [W_K-1:0]       dad_q  [QW];
  logic [1:0][QW-1:0]   dquo_q [QW+1];
  logic [1:0]           dbig_q [QW+1];
  rci_pkg::dsd_t        dsd_q  [QW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        dbig_q[0][l] <= CW'(an_q[l]) >= (CW'(ad_q) << QW);
      end
      drem_q[0] <= an_q;
      dquo_q[0] <= '0;
      dad_q[0]  <= ad_q;
      dsd_q[0]  <= asd_q;
    end
  end

  for (genvar t = 0; t < QW; t++) begin : g_div
    logic [CW-1:0] dsh;
    logic [1:0]    ge;

    assign dsh = CW'(dad_q[t]) << (QW - 1 - t);

    for (genvar l = 0; l < 2; l++) begin : g_ln
      assign ge[l] = CW'(drem_q[t][l]) >= dsh;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          dquo_q[t+1][l] <= {dquo_q[t][l][QW-2:0], ge[l]};
        end
        dbig_q[t+1] <= dbig_q[t];
        dsd_q[t+1]  <= dsd_q[t];
      end
    end

    if (t < QW - 1) begin : g_fw
      always_ff @(posedge clk_i) begin
        if (en) begin
          for (int l = 0; l < 2; l++) begin
            drem_q[t+1][l] <= ge[l] ? W_N'(CW'(drem_q[t][l]) - dsh) : drem_q[t][l];
          end
          dad_q[t+1] <= dad_q[t];
        end
      end
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vk_q <= 1'b0;
      vq_q <= 1'b0;
      vr_q <= 1'b0;
      va_q <= 1'b0;
      dv_q <= '0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      vk_q <= m2_v;
      vq_q <= m3_v;
      vr_q <= sr_v;
      va_q <= vr_q;
      dv_q <= {dv_q[QW-1:0], va_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Saturate, apply the miss value, and push into the output buffer.
  // ---------------------------------------------------------------------------
  rci_pkg::out_t res;
  rci_pkg::out_t buf_q [2];
  logic          push, pop, wr_sel;

  always_comb begin
    res.hit = dsd_q[QW].hit;
    if (dsd_q[QW].hit) begin
      res.root_plus  = rci_pkg::sat_root(dquo_q[QW][0], dbig_q[QW][0], dsd_q[QW].neg_p);
      res.root_minus = rci_pkg::sat_root(dquo_q[QW][1], dbig_q[QW][1], dsd_q[QW].neg_m);
    end else begin
      res.root_plus  = MAX_DISTANCE;
      res.root_minus = MAX_DISTANCE;
    end
  end

  assign push   = en && dv_q[QW];
  assign pop    = out_valid_o && out_ready_i;
  assign wr_sel = (cnt_q != 2'd0) && !pop;
  assign cnt_d  = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Load the new beat at the head when the head frees up, else shift on a pop;
  // otherwise drop the new beat behind the survivor
  always_ff @(posedge clk_i) begin
    if (push && !wr_sel) begin
      buf_q[0] <= res;
    end else if (pop) begin
      buf_q[0] <= buf_q[1];
    end
    if (push && wr_sel) begin
      buf_q[1] <= res;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[0];

  // Buffer never holds more than two beats
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer overfilled");

  // A stall only happens with a beat waiting at the output
  a_stall_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // A full buffer cannot take a new beat in the same cycle
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !push)
    else $error("push into full output buffer");

  // A miss always reports the far distance on both roots
  a_miss_far: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.hit) |->
      (out_data_o.root_plus == MAX_DISTANCE && out_data_o.root_minus == MAX_DISTANCE))
    else $error("miss with a finite root");

endmodule

// ===== tb/sv/tb_ray_cone_intersection.sv =====
`timescale 1ns / 1ps

module tb_ray_cone_intersection;

  // Wide enough for every exact intermediate (discriminant stays below 2^332)
  typedef logic signed [399:0] wide_t;

  localparam int unsigned DRAIN   = 240;   // pipeline latency plus margin
  localparam int unsigned HOLD    = 600;   // long receiver hold-off
  localparam int unsigned WD_MAX  = 4000;  // cycles with no beat on either side
  localparam int unsigned PER_PHASE = 275;

  localparam logic [31:0] MAX_DISTANCE_TB = 32'h7FFF_FFFF;

  // Predict cone hits for each accepted ray and match them against returned beats
  class cone_scoreboard;
    logic signed [31:0] apex [3];
    logic signed [17:0] axis [3];
    logic [30:0]        slope;
    rci_pkg::out_t      pending [$];
    int                 errors;

    function new();
      apex = '{0, 0, 0};
      axis = '{18'sd0, 18'sd65536, 18'sd0};
      slope = 31'd65536;
      errors = 0;
    endfunction

    function void set_reg(rci_pkg::cfg_idx_e idx, logic [31:0] val);
      case (idx)
        rci_pkg::CFG_APEX_X: apex[0] = val;
        rci_pkg::CFG_APEX_Y: apex[1] = val;
        rci_pkg::CFG_APEX_Z: apex[2] = val;
        rci_pkg::CFG_AXIS_X: axis[0] = val[17:0];
        rci_pkg::CFG_AXIS_Y: axis[1] = val[17:0];
        rci_pkg::CFG_AXIS_Z: axis[2] = val[17:0];
        rci_pkg::CFG_SLOPE:  slope = val[30:0];
        default: ;
      endcase
    endfunction

    static function wide_t floor_sqrt(wide_t v);
      logic [399:0] num, res, bt;
      num = v;
      res = '0;
      bt = 400'd1 << 398;
      while (bt != 0 && bt > num) bt = bt >> 2;
      while (bt != 0) begin
        if (num >= res + bt) begin
          num = num - res - bt;
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return wide_t'(res);
    endfunction

    // Truncate toward zero, then clamp to the signed 32-bit range
    static function logic [31:0] clamp_quot(wide_t n, wide_t d);
      logic [399:0] an, ad, q;
      logic         neg;
      neg = (n < 0) != (d < 0);
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = an / ad;
      if (neg) return (q > 400'h8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
      return (q > 400'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function void note_ray(rci_pkg::in_t ray);
      wide_t d [3], x [3], v [3];
      wide_t bb, bv, bx, xv, xx, m, k1, h, k3, disc, r;
      rci_pkg::out_t res;
      d[0] = wide_t'(ray.dir_x);
      d[1] = wide_t'(ray.dir_y);
      d[2] = wide_t'(ray.dir_z);
      x[0] = wide_t'(ray.origin_x) - wide_t'(apex[0]);
      x[1] = wide_t'(ray.origin_y) - wide_t'(apex[1]);
      x[2] = wide_t'(ray.origin_z) - wide_t'(apex[2]);
      for (int i = 0; i < 3; i++) v[i] = wide_t'(axis[i]);
      bb = 0; bv = 0; bx = 0; xv = 0; xx = 0;
      for (int i = 0; i < 3; i++) begin
        bb += d[i] * d[i];
        bv += d[i] * v[i];
        bx += d[i] * x[i];
        xv += x[i] * v[i];
        xx += x[i] * x[i];
      end
      m = (wide_t'(1) <<< 32) + wide_t'({1'b0, slope}) * wide_t'({1'b0, slope});
      k1 = (bb <<< 64) - m * bv * bv;
      h  = (bx <<< 64) - m * bv * xv;
      k3 = (xx <<< 64) - m * xv * xv;
      disc = h * h - k1 * k3;
      if (disc < 0 || k1 == 0) begin
        res.root_plus  = MAX_DISTANCE_TB;
        res.root_minus = MAX_DISTANCE_TB;
        res.hit        = 1'b0;
      end else begin
        r = floor_sqrt(disc);
        res.root_plus  = clamp_quot((r - h) <<< 16, k1);
        res.root_minus = clamp_quot((-h - r) <<< 16, k1);
        res.hit        = 1'b1;
      end
      pending.push_back(res);
    endfunction

    function void check_hit(rci_pkg::out_t got);
      rci_pkg::out_t want;
      if (pending.size() == 0) begin
        $error("unexpected result beat: plus=%0d minus=%0d hit=%0b",
               got.root_plus, got.root_minus, got.hit);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.root_plus !== want.root_plus) begin
        $error("root_plus: expected %0d, got %0d", want.root_plus, got.root_plus);
        errors++;
      end
      if (got.root_minus !== want.root_minus) begin
        $error("root_minus: expected %0d, got %0d", want.root_minus, got.root_minus);
        errors++;
      end
      if (got.hit !== want.hit) begin
        $error("hit: expected %0b, got %0b", want.hit, got.hit);
        errors++;
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_ready_o;
  rci_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_ready_i;
  rci_pkg::out_t out_data_o;
  logic          cfg_we_i;
  logic [2:0]    cfg_idx_i;
  logic [31:0]   cfg_data_i;

  cone_scoreboard sb;

  int unsigned send_idle_pct;   // chance in a hundred that the sender skips a cycle
  int unsigned recv_stall_pct;  // chance in a hundred that the receiver stalls
  logic        hold_req;        // ask the receiver for one long hold-off
  logic        hold_taken;      // the receiver has served the hold-off request
  int unsigned hold_left;
  int unsigned quiet_cycles;

  ray_cone_intersection DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Receiver: random stalls, plus one long hold-off counted here on request
  always @(posedge clk_i) begin
    if (rst_ni !== 1'b1) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_ready_i <= 1'b0;
      hold_left <= HOLD;
      hold_taken <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor both channels on the edge; values seen here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_ray(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_hit(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WD_MAX) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Mix full-range, small, near-unit and extreme coordinates
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      2: return ($urandom_range(40) - 20) <<< 16;
      default: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  function automatic rci_pkg::in_t random_ray();
    rci_pkg::in_t ray;
    ray.origin_x = pick_coord();
    ray.origin_y = pick_coord();
    ray.origin_z = pick_coord();
    ray.dir_x    = pick_coord();
    ray.dir_y    = pick_coord();
    ray.dir_z    = pick_coord();
    return ray;
  endfunction

  function automatic rci_pkg::in_t make_ray(int ox, int oy, int oz, int dx, int dy, int dz);
    rci_pkg::in_t ray;
    ray.origin_x = ox;
    ray.origin_y = oy;
    ray.origin_z = oz;
    ray.dir_x    = dx;
    ray.dir_y    = dy;
    ray.dir_z    = dz;
    return ray;
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_ray(rci_pkg::in_t ray);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ray;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Drive one register write; the caller drops the write enable afterwards
  task automatic cfg_write(rci_pkg::cfg_idx_e idx, logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic load_cone(int ax, int ay, int az, int vx, int vy, int vz, int k);
    cfg_write(rci_pkg::CFG_APEX_X, ax);
    cfg_write(rci_pkg::CFG_APEX_Y, ay);
    cfg_write(rci_pkg::CFG_APEX_Z, az);
    cfg_write(rci_pkg::CFG_AXIS_X, vx);
    cfg_write(rci_pkg::CFG_AXIS_Y, vy);
    cfg_write(rci_pkg::CFG_AXIS_Z, vz);
    cfg_write(rci_pkg::CFG_SLOPE, k);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  initial begin
    sb = new();
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    hold_req    <= 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rays against the reset cone (apex at origin, axis +y, 45 degrees)
    send_ray(make_ray(0, 0, 0, 0, 0, 0));                           // zero direction
    send_ray(make_ray(0, -32'sh50000, 0, 0, 32'sh10000, 0));        // along the axis
    send_ray(make_ray(32'sh30000, 0, 0, 0, 0, 32'sh10000));         // misses, negative disc
    send_ray(make_ray(0, 32'sh10000, 32'sh20000, 0, 0, -32'sh10000)); // crosses the nappe
    send_ray(make_ray(0, 0, 0, 32'sh10000, 32'sh10000, 0));         // along the surface
    send_ray(make_ray(0, 32'sh10000, 0, 1, 0, 0));                  // tiny direction, saturates
    send_ray(make_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_ray(make_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                      32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_ray(make_ray(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'sh7FFF_FFFF, 1, -1));
    send_ray(make_ray(-1, -1, -1, -1, -1, -1));
    send_ray(make_ray(0, 32'sh10000, 0, 32'sh10000, 0, 0));         // horizontal through nappe
    drain();

    // Directed rays on extreme cones: slope zero is a line, max slope is nearly flat
    load_cone(32'sh7FFF_FFFF, 32'sh8000_0000, 0, -65536, 0, 0, 0);
    send_ray(make_ray(0, 32'sh8000_0000, 0, 32'sh10000, 0, 0));
    send_ray(make_ray(0, 0, 0, 0, 32'sh10000, 0));
    send_ray(random_ray());
    drain();
    load_cone(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, -65536, 32'h7FFF_FFFF);
    send_ray(make_ray(0, 0, 0, 0, 0, 32'sh10000));
    send_ray(make_ray(0, 0, 0, 32'sh10000, 0, 0));
    send_ray(random_ray());
    drain();

    // Random phases, each on its own cone and idling mix
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_cone(0, 0, 0, 0, 65536, 0, 65536);
        1: load_cone(32'sh20000, -32'sh10000, 32'sh8000, 65536, 0, 0, 32'sh8000);
        2: load_cone(0, 0, 0, 46341, 46341, 0, 32'sh30000);
        3: load_cone($urandom, $urandom, $urandom, $urandom_range(131072) - 65536,
                     $urandom_range(131072) - 65536, $urandom_range(131072) - 65536,
                     $urandom_range(32'h7FFF_FFFF));
        4: load_cone(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 65536, 65536, 65536,
                     32'h7FFF_FFFF);
        default: load_cone($urandom_range(65535) - 32768, 0, 0, 0, -65536, 0,
                           $urandom_range(32'h3_0000));
      endcase
      set_idling(ph);
      // Fill the pipe against a long receiver hold-off
      if (ph == 1) hold_req <= 1'b1;
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == 2 && n == PER_PHASE / 2) begin
          // Pause the sender until every outstanding ray has come back
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (sb.pending.size() != 0) @(posedge clk_i);
        end
        if (ph >= 4 && n % 50 == 0) set_idling($urandom_range(3));
        send_ray(random_ray());
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
